// ===== design/pcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcsc_pkg: shared types, constants and functions
// Character classes, enzyme rule codes and item/result structures for the
// peptide cleavage site counter.
// ----------------------------------------------------------------------------
package pcsc_pkg;

  localparam int MAX_LEN   = 255;
  localparam int POS_W     = $clog2(MAX_LEN + 1);
  localparam int COUNT_CAP = (MAX_LEN < 255) ? MAX_LEN : 255;
  localparam int CNT_W     = 8;
  localparam int MIN_LEN   = 5;

  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_W    = 8'h57;
  localparam logic [7:0] CH_Y    = 8'h59;
  localparam logic [7:0] CH_L    = 8'h4C;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_V    = 8'h56;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_AT   = 8'h40;

  localparam int N_AMINO = 20;
  localparam logic [7:0] AMINO_SET [N_AMINO] = '{
    8'h41, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4B, 8'h4C,
    8'h4D, 8'h4E, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h56, 8'h57, 8'h59
  };

  typedef enum logic [1:0] {
    ENZ_NONE     = 2'd0,
    ENZ_TRYPSIN  = 2'd1,
    ENZ_CHYMO    = 2'd2,
    ENZ_ELASTASE = 2'd3
  } enzyme_t;

  typedef struct packed {
    logic [7:0] residue_char;
    logic       last_char;
  } item_t;

  typedef struct packed {
    logic             nterm_cleaved;
    logic             cterm_cleaved;
    logic [CNT_W-1:0] internal_cleavages;
    logic [CNT_W-1:0] residue_count;
    logic [CNT_W-1:0] mod_count;
    logic             too_short;
  } result_t;

  function automatic logic is_amino(input logic [7:0] ch);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < N_AMINO; i++) begin
      if (ch == AMINO_SET[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic is_mark(input logic [7:0] ch);
    return (ch == CH_HASH) || (ch == CH_STAR) || (ch == CH_AT);
  endfunction

  function automatic logic rule_match(input enzyme_t mode, input logic [7:0] n,
                                      input logic [7:0] c);
    logic site;
    logic hit;
    site = 1'b0;
    hit  = 1'b0;
    unique case (mode)
      ENZ_NONE: begin
        site = 1'b0;
      end
      ENZ_TRYPSIN: begin
        site = (n == CH_K) || (n == CH_R);
      end
      ENZ_CHYMO: begin
        site = (n == CH_F) || (n == CH_H) || (n == CH_W) || (n == CH_Y) ||
               (n == CH_L) || (n == CH_M);
      end
      ENZ_ELASTASE: begin
        site = (n == CH_L) || (n == CH_V) || (n == CH_A) || (n == CH_G);
      end
      default: begin
        site = 1'b0;
      end
    endcase
    if (mode != ENZ_NONE) begin
      hit = (site && (c != CH_P)) || (n == CH_DASH) || (c == CH_DASH);
    end
    return hit;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v < CNT_W'(COUNT_CAP)) ? v + CNT_W'(1) : v;
  endfunction

endpackage

// ===== design/peptide_cleavage_site_counter_unit.sv =====
// ----------------------------------------------------------------------------
// peptide_cleavage_site_counter_unit: flanked peptide cleavage site counter
// Path: a final character waits in the input register, then its result is
// loaded into the result register (a held result can stall the load).
// Throughput: one character per cycle; the evaluation stage stalls only when
// a final character meets a result register that is still held.
// Reset: synchronous active-low rst_n clears string state, enzyme_mode = 1.
// ----------------------------------------------------------------------------
module peptide_cleavage_site_counter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,  // enzyme_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] residue_char
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [0] nterm_cleaved, [1] cterm_cleaved,
                                  // [9:2] internal_cleavages,
                                  // [17:10] residue_count, [25:18] mod_count
  output logic        out_tuser   // too_short
);

  pcsc_pkg::enzyme_t mode_r;
  pcsc_pkg::item_t   item;
  pcsc_pkg::result_t result;
  logic              item_valid;
  logic              out_busy;
  logic              advance;
  logic              out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pcsc_pkg::ENZ_TRYPSIN;
    end else if (cfg_we) begin
      mode_r <= pcsc_pkg::enzyme_t'(cfg_wdata);
    end
  end

  assign advance  = item_valid && !(item.last_char && out_busy);
  assign out_load = advance && item.last_char;

  pcsc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  pcsc_site_eval u_site_eval (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (item),
    .mode   (mode_r),
    .result (result)
  );

  pcsc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (out_load),
    .result     (result),
    .busy       (out_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> item_valid)
    else $error("input stalled with empty input register");

  a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid)
    else $error("final character did not produce a result");

  a_short_zero_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 32'd0))
    else $error("short string result carries nonzero counts");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !out_load)
    else $error("held result overwritten");

endmodule

// ===== design/pcsc_in_reg.sv =====
// ----------------------------------------------------------------------------
// pcsc_in_reg: input register
// Holds one character request until the evaluation stage takes it.
// ----------------------------------------------------------------------------
module pcsc_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,   // [7:0] residue_char
  input  logic            in_tlast,   // last_char
  input  logic            advance,
  output logic            item_valid,
  output pcsc_pkg::item_t item
);

  logic            valid_r;
  logic            valid_nxt;
  pcsc_pkg::item_t item_r;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) valid_nxt = in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.residue_char <= in_tdata;
      item_r.last_char    <= in_tlast;
    end
  end

endmodule

// ===== design/pcsc_site_eval.sv =====
// ----------------------------------------------------------------------------
// pcsc_site_eval: string state and cleavage evaluation
// Tracks position, history and running counts of one flanked string and
// forms the result for the final character.
// ----------------------------------------------------------------------------
module pcsc_site_eval (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  pcsc_pkg::item_t   item,
  input  pcsc_pkg::enzyme_t mode,
  output pcsc_pkg::result_t result
);

  logic [7:0]                 hist0_r, hist1_r, hist2_r;
  logic [7:0]                 first_r;
  logic [pcsc_pkg::POS_W-1:0] pos_r;
  logic [pcsc_pkg::CNT_W-1:0] pair_r, aa_r, mark_r;
  logic                       nterm_r;

  logic [7:0]                 first_nxt;
  logic [pcsc_pkg::POS_W-1:0] pos_nxt;
  logic [pcsc_pkg::CNT_W-1:0] pair_nxt, aa_nxt, mark_nxt;
  logic                       nterm_nxt;
  logic [pcsc_pkg::POS_W-1:0] count_now;
  logic                       at_max;

  assign at_max    = (pos_r == pcsc_pkg::POS_W'(pcsc_pkg::MAX_LEN));
  assign count_now = at_max ? pos_r : pos_r + pcsc_pkg::POS_W'(1);

  always_comb begin
    first_nxt = first_r;
    nterm_nxt = nterm_r;
    aa_nxt    = aa_r;
    mark_nxt  = mark_r;
    pair_nxt  = pair_r;
    if (pos_r == pcsc_pkg::POS_W'(0)) first_nxt = item.residue_char;
    if (pos_r == pcsc_pkg::POS_W'(2)) begin
      nterm_nxt = pcsc_pkg::rule_match(mode, first_r, item.residue_char);
    end
    if (pos_r >= pcsc_pkg::POS_W'(4)) begin
      if (pcsc_pkg::is_amino(hist1_r)) aa_nxt = pcsc_pkg::sat_inc(aa_r);
      if (pcsc_pkg::is_mark(hist1_r)) mark_nxt = pcsc_pkg::sat_inc(mark_r);
      if ((pos_r >= pcsc_pkg::POS_W'(5)) && pcsc_pkg::rule_match(mode, hist2_r, hist1_r)) begin
        pair_nxt = pcsc_pkg::sat_inc(pair_r);
      end
    end
    pos_nxt = count_now;
  end

  always_comb begin
    result = '0;
    if (count_now < pcsc_pkg::POS_W'(pcsc_pkg::MIN_LEN)) begin
      result.too_short = 1'b1;
    end else begin
      result.nterm_cleaved      = nterm_nxt;
      result.cterm_cleaved      = pcsc_pkg::rule_match(mode, hist1_r, item.residue_char);
      result.internal_cleavages = pair_nxt;
      result.residue_count      = aa_nxt;
      result.mod_count          = mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist0_r <= '0;
      hist1_r <= '0;
      hist2_r <= '0;
      first_r <= '0;
      pos_r   <= '0;
      pair_r  <= '0;
      aa_r    <= '0;
      mark_r  <= '0;
      nterm_r <= 1'b0;
    end else if (step) begin
      if (item.last_char) begin
        hist0_r <= '0;
        hist1_r <= '0;
        hist2_r <= '0;
        first_r <= '0;
        pos_r   <= '0;
        pair_r  <= '0;
        aa_r    <= '0;
        mark_r  <= '0;
        nterm_r <= 1'b0;
      end else begin
        hist2_r <= hist1_r;
        hist1_r <= hist0_r;
        hist0_r <= item.residue_char;
        first_r <= first_nxt;
        pos_r   <= pos_nxt;
        pair_r  <= pair_nxt;
        aa_r    <= aa_nxt;
        mark_r  <= mark_nxt;
        nterm_r <= nterm_nxt;
      end
    end
  end

endmodule

// ===== design/pcsc_out_reg.sv =====
// ----------------------------------------------------------------------------
// pcsc_out_reg: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module pcsc_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  pcsc_pkg::result_t result,
  output logic              busy,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // [0] nterm_cleaved, [1] cterm_cleaved,
                                        // [9:2] internal_cleavages,
                                        // [17:10] residue_count, [25:18] mod_count
  output logic              out_tuser   // too_short
);

  logic              valid_r;
  logic              valid_nxt;
  pcsc_pkg::result_t res_r;

  assign busy       = valid_r && !out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {6'd0, res_r.mod_count, res_r.residue_count,
                       res_r.internal_cleavages, res_r.cterm_cleaved, res_r.nterm_cleaved};
  assign out_tuser  = res_r.too_short;

  always_comb begin
    valid_nxt = valid_r;
    if (out_tready) valid_nxt = 1'b0;
    if (load) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= result;
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: peptide cleavage site counter testbench
// Streams flanked peptide strings through the block one character per
// request and checks each result against a cycle-free predictor. It covers
// every enzyme rule, short, exact-minimum and saturating long strings, and
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

  class cleavage_scoreboard;
    pcsc_pkg::enzyme_t rule;
    logic [7:0]        hist [3];
    logic [7:0]        lead_char;
    int unsigned       pos;
    logic [7:0]        pairs;
    logic [7:0]        residues;
    logic [7:0]        marks;
    logic              nterm_hit;
    pcsc_pkg::result_t expected_q [$];
    int unsigned       mismatches;
    int unsigned       results_checked;
    int unsigned       chars_taken;

    function new();
      rule            = pcsc_pkg::ENZ_TRYPSIN;
      mismatches      = 0;
      results_checked = 0;
      chars_taken     = 0;
      clear_peptide();
    endfunction

    function void clear_peptide();
      hist      = '{8'h00, 8'h00, 8'h00};
      lead_char = 8'h00;
      pos       = 0;
      pairs     = 8'h00;
      residues  = 8'h00;
      marks     = 8'h00;
      nterm_hit = 1'b0;
    endfunction

    function logic is_residue(logic [7:0] ch);
      case (ch)
        "A", "C", "D", "E", "F", "G", "H", "I", "K", "L",
        "M", "N", "P", "Q", "R", "S", "T", "V", "W", "Y": return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function logic is_modification(logic [7:0] ch);
      return (ch == "#") || (ch == "*") || (ch == "@");
    endfunction

    function logic cleaves(logic [7:0] n, logic [7:0] c);
      logic site;
      case (rule)
        pcsc_pkg::ENZ_TRYPSIN:  site = (n == "K") || (n == "R");
        pcsc_pkg::ENZ_CHYMO:    site = (n == "F") || (n == "H") || (n == "W") ||
                                       (n == "Y") || (n == "L") || (n == "M");
        pcsc_pkg::ENZ_ELASTASE: site = (n == "L") || (n == "V") || (n == "A") ||
                                       (n == "G");
        default:                return 1'b0;
      endcase
      return (site && (c != "P")) || (n == "-") || (c == "-");
    endfunction

    function logic [7:0] bump(logic [7:0] v);
      return (v < pcsc_pkg::COUNT_CAP) ? v + 8'd1 : v;
    endfunction

    function void note_request(logic [7:0] ch, logic last);
      int unsigned       len_now;
      pcsc_pkg::result_t r;
      chars_taken++;
      if (pos == 0) lead_char = ch;
      if (pos == 2) nterm_hit = cleaves(lead_char, ch);
      if (pos >= 4) begin
        if (is_residue(hist[1])) residues = bump(residues);
        if (is_modification(hist[1])) marks = bump(marks);
        if (pos >= 5 && cleaves(hist[2], hist[1])) pairs = bump(pairs);
      end
      len_now = (pos < pcsc_pkg::MAX_LEN) ? pos + 1 : pos;
      if (last) begin
        r = '0;
        if (len_now < pcsc_pkg::MIN_LEN) begin
          r.too_short = 1'b1;
        end else begin
          r.nterm_cleaved      = nterm_hit;
          r.cterm_cleaved      = cleaves(hist[1], ch);
          r.internal_cleavages = pairs;
          r.residue_count      = residues;
          r.mod_count          = marks;
        end
        expected_q = {expected_q, r};
        clear_peptide();
      end else begin
        hist[2] = hist[1];
        hist[1] = hist[0];
        hist[0] = ch;
        pos     = len_now;
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [31:0] data, logic short_flag);
      pcsc_pkg::result_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        $error("result with no peptide pending: tdata=%h tuser=%b", data, short_flag);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("nterm_cleaved", 8'(want.nterm_cleaved), 8'(data[0]));
      compare_field("cterm_cleaved", 8'(want.cterm_cleaved), 8'(data[1]));
      compare_field("internal_cleavages", want.internal_cleavages, data[9:2]);
      compare_field("residue_count", want.residue_count, data[17:10]);
      compare_field("mod_count", want.mod_count, data[25:18]);
      compare_field("tdata padding", 8'h00, {2'b00, data[31:26]});
      compare_field("too_short", 8'(want.too_short), 8'(short_flag));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = 2'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned chars_sent = 0;

  cleavage_scoreboard sb = new();

  peptide_cleavage_site_counter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  function logic [7:0] core_char();
    string       letters;
    int unsigned r;
    letters = "ACDEFGHIKLMNPQRSTVWY";
    r = $urandom_range(99);
    if (r < 60) return letters[$urandom_range(19)];
    if (r < 70) begin
      letters = "#*@";
      return letters[$urandom_range(2)];
    end
    if (r < 78) return "-";
    if (r < 86) return "P";
    if (r < 92) return 8'($urandom_range(122, 97));
    return 8'($urandom_range(255));
  endfunction

  function logic [7:0] flank_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return "K";
    if (r < 40) return "R";
    if (r < 55) return "-";
    if (r < 65) return "P";
    return core_char();
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_request(ch, last);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_bytes(input logic [7:0] seq [$]);
    foreach (seq[i]) send_char(seq[i], i == seq.size() - 1);
  endtask

  task automatic send_text(input string s);
    logic [7:0] seq [$];
    for (int i = 0; i < s.len(); i++) seq = {seq, s[i]};
    send_bytes(seq);
  endtask

  task automatic send_peptide(input int len, input logic [7:0] fill);
    logic [7:0] seq [$];
    bit         shaped;
    shaped = ($urandom_range(99) < 85) || (fill != 8'h00);
    for (int i = 0; i < len; i++) begin
      if (!shaped) seq = {seq, 8'($urandom_range(255))};
      else if (i == 0 || i == len - 1) seq = {seq, flank_char()};
      else if (i == 1 || i == len - 2) seq = {seq, 8'h2E};
      else if (fill != 8'h00 && $urandom_range(19) != 0) seq = {seq, fill};
      else seq = {seq, core_char()};
    end
    send_bytes(seq);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_enzyme(input pcsc_pkg::enzyme_t mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    sb.rule = mode;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned phase_start;
    int unsigned r;
    logic [7:0]  directed [$];
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_text("R");
    send_text("K.AP");
    send_text("K.R.P");
    directed = '{"-", ".", "K", "#", 8'hFF, "@", "*", "P", "a", 8'h00, "-", ".", "R"};
    send_bytes(directed);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      drain_results();
      write_enzyme(pcsc_pkg::enzyme_t'((ph + ph / 4) % 4));
      phase_start = chars_sent;
      while (chars_sent - phase_start < 20) begin
        r = $urandom_range(99);
        if (r < 10) send_peptide($urandom_range(4, 1), 8'h00);
        else if (r < 85) send_peptide($urandom_range(16, 5), 8'h00);
        else send_peptide($urandom_range(40, 17), 8'h00);
      end
      if (ph == 1) send_peptide(300, "K");
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d characters and checked %0d peptide results under all four enzyme rules,",
             sb.chars_taken, sb.results_checked);
    $display("including short and saturating strings, with sender gaps and receiver stalls.");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
